// ----- rtl/ddsm_pkg.sv -----
// shared types and constants of the dual dds sine mixer
// used by ddsm_ctrl, ddsm_datapath and dual_dds_sine_mixer_unit; no dependencies
`default_nettype none

package ddsm_pkg;

  localparam int TABLE_DEPTH_DEF         = 64;
  localparam int PHASE_FRACTION_BITS_DEF = 16;
  localparam int PHASE_W                 = 32;

  localparam real TWO_PI = 6.283185307179586;

  // cycle of the run count at which the resonator result leaves the pipeline
  localparam logic [3:0] RUN_LAST = 4'd8;
  localparam logic [3:0] RUN_RES  = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic issue_res;
    logic mix_load;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ddsm_ctrl.sv -----
// controller of the dual dds sine mixer: input and output handshakes, run sequencing
// depends on ddsm_pkg
`default_nettype none

module ddsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ddsm_pkg::cmd_t     cmd
);

  ddsm_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddsm_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ddsm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ddsm_pkg::ST_RUN;
        end
      end
      ddsm_pkg::ST_RUN: begin
        cnt_next      = cnt + 4'd1;
        cmd.issue_res = (cnt == ddsm_pkg::RUN_RES);
        if (cnt == ddsm_pkg::RUN_LAST) begin
          cmd.mix_load = 1'b1;
          state_next   = ddsm_pkg::ST_WRITE;
        end
      end
      ddsm_pkg::ST_WRITE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ddsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ddsm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ddsm_datapath.sv -----
// datapath of the dual dds sine mixer: phase accumulators, index reduction,
// sine table, interpolation, gain, mix and clamp; depends on ddsm_pkg
`default_nettype none

module ddsm_datapath #(
  parameter int TABLE_DEPTH         = ddsm_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_FRACTION_BITS = ddsm_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ddsm_pkg::cmd_t cmd,
  input  wire logic [31:0]    main_step,
  input  wire logic [31:0]    res_step,
  input  wire logic [7:0]     level8,
  input  wire logic [15:0]    level_mul16,
  input  wire logic [15:0]    res_amp16,
  input  wire logic           decay_active,
  output logic [7:0]          dac_sample
);

  localparam int PhaseW = ddsm_pkg::PHASE_W;
  localparam int FracW  = PHASE_FRACTION_BITS;
  localparam int RawW   = PhaseW - FracW;
  localparam int AddrW  = $clog2(TABLE_DEPTH);
  localparam int DprodW = FracW + 10;

  localparam logic [RawW-1:0]  Recip   = RawW'((64'd1 << RawW) / TABLE_DEPTH);
  localparam logic [RawW-1:0]  Depth   = RawW'(TABLE_DEPTH);
  localparam logic [AddrW:0]   DepthA  = (AddrW+1)'(TABLE_DEPTH);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(TABLE_DEPTH - 1);

  // sine table, entry i = round(128 + 127*sin(2*pi*i/depth)), halves away from zero
  logic [7:0] rom_tbl [TABLE_DEPTH];

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
    localparam real Ang    = ddsm_pkg::TWO_PI * gi / TABLE_DEPTH;
    localparam real Val    = 128.0 + 127.0 * $sin(Ang);
    localparam int  Twelve = 12 * gi;
    localparam int  TwRem  = Twelve % TABLE_DEPTH;
    localparam int  TwQuo  = Twelve / TABLE_DEPTH;
    localparam int  Entry  =
      ((TwRem == 0) && ((TwQuo == 1) || (TwQuo == 5))) ? 192 :
      ((TwRem == 0) && ((TwQuo == 7) || (TwQuo == 11))) ? 65 : $rtoi(Val + 0.5);
    assign rom_tbl[gi] = 8'(Entry);
  end

  logic [31:0] main_phase, res_phase;
  logic        decay_q;
  logic [7:0]  gain_main, gain_res;

  logic [23:0] lvl_mul, amp_mul;

  assign lvl_mul = level8 * level_mul16;
  assign amp_mul = res_amp16 * 8'd255;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase <= '0;
      res_phase  <= '0;
    end else if (cmd.load) begin
      main_phase <= main_phase + main_step;
      if (decay_active) begin
        res_phase <= res_phase + res_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      decay_q   <= decay_active;
      gain_main <= decay_active ? lvl_mul[23:16] : level8;
      gain_res  <= amp_mul[23:16];
    end
  end

  // stage 1: phase select, reciprocal multiply
  logic [PhaseW-1:0] phase_sel;
  logic [RawW-1:0]   raw_s1;
  logic [FracW-1:0]  frac_s1;
  logic [2*RawW-1:0] prod_s1;
  logic              tag_s1;

  assign phase_sel = cmd.issue_res ? res_phase : main_phase;

  always_ff @(posedge clk) begin
    raw_s1  <= phase_sel[PhaseW-1:FracW];
    frac_s1 <= phase_sel[FracW-1:0];
    prod_s1 <= phase_sel[PhaseW-1:FracW] * Recip;
    tag_s1  <= cmd.issue_res;
  end

  // stage 2: quotient times depth
  logic [RawW-1:0]   quot;
  logic [2*RawW-1:0] qd_full;
  logic [RawW-1:0]   raw_s2, qd_s2;
  logic [FracW-1:0]  frac_s2;
  logic              tag_s2;

  assign quot    = prod_s1[2*RawW-1:RawW];
  assign qd_full = quot * Depth;

  always_ff @(posedge clk) begin
    raw_s2  <= raw_s1;
    qd_s2   <= qd_full[RawW-1:0];
    frac_s2 <= frac_s1;
    tag_s2  <= tag_s1;
  end

  // stage 3: remainder with one correction, next index
  logic [RawW-1:0]       rem;
  logic [RawW+AddrW:0]   rem_x;
  logic [AddrW:0]        rem_a, rem_c;
  logic [AddrW-1:0]      idx_c, nxt_c;
  logic [AddrW-1:0]      idx_s3, nxt_s3;
  logic [FracW-1:0]      frac_s3;
  logic                  tag_s3;

  assign rem   = raw_s2 - qd_s2;
  assign rem_x = {{(AddrW+1){1'b0}}, rem};
  assign rem_a = rem_x[AddrW:0];
  assign rem_c = (rem_a >= DepthA) ? (rem_a - DepthA) : rem_a;
  assign idx_c = rem_c[AddrW-1:0];
  assign nxt_c = (idx_c == LastIdx) ? '0 : (idx_c + AddrW'(1));

  always_ff @(posedge clk) begin
    idx_s3  <= idx_c;
    nxt_s3  <= nxt_c;
    frac_s3 <= frac_s2;
    tag_s3  <= tag_s2;
  end

  // stage 4: table read
  logic [7:0]       rom_a_s4, rom_b_s4;
  logic [FracW-1:0] frac_s4;
  logic             tag_s4;

  always_ff @(posedge clk) begin
    rom_a_s4 <= rom_tbl[idx_s3];
    rom_b_s4 <= rom_tbl[nxt_s3];
    frac_s4  <= frac_s3;
    tag_s4   <= tag_s3;
  end

  // stage 5: slope times fraction
  logic signed [8:0]        diff;
  logic signed [DprodW-1:0] dprod_s5;
  logic [7:0]               a_s5;
  logic                     tag_s5;

  assign diff = $signed({1'b0, rom_b_s4}) - $signed({1'b0, rom_a_s4});

  always_ff @(posedge clk) begin
    dprod_s5 <= diff * $signed({1'b0, frac_s4});
    a_s5     <= rom_a_s4;
    tag_s5   <= tag_s4;
  end

  // stage 6: interpolated and centered sample
  logic signed [DprodW-1:0] delta_w;
  logic signed [9:0]        cent_w;
  logic signed [8:0]        cent_s6;
  logic                     tag_s6;

  assign delta_w = dprod_s5 >>> FracW;
  assign cent_w  = $signed({2'b00, a_s5}) + $signed(delta_w[9:0]) - 10'sd128;

  always_ff @(posedge clk) begin
    cent_s6 <= cent_w[8:0];
    tag_s6  <= tag_s5;
  end

  // stage 7: gain, floor shift by 8
  logic [7:0]         gain_sel;
  logic signed [17:0] sprod;
  logic signed [9:0]  scaled_s7, scaled_prev;

  assign gain_sel = tag_s6 ? gain_res : gain_main;
  assign sprod    = cent_s6 * $signed({1'b0, gain_sel});

  always_ff @(posedge clk) begin
    scaled_s7   <= sprod[17:8];
    scaled_prev <= scaled_s7;
  end

  // mix, re-bias and clamp
  logic signed [10:0] mix_q;
  logic signed [11:0] biased;

  assign biased = $signed({mix_q[10], mix_q}) + 12'sd128;

  always_ff @(posedge clk) begin
    if (cmd.mix_load) begin
      mix_q <= decay_q ? ($signed({scaled_prev[9], scaled_prev}) +
                          $signed({scaled_s7[9], scaled_s7}))
                       : $signed({scaled_prev[9], scaled_prev});
    end
    if (cmd.out_load) begin
      if (biased < 12'sd0) begin
        dac_sample <= 8'd0;
      end else if (biased > 12'sd255) begin
        dac_sample <= 8'd255;
      end else begin
        dac_sample <= biased[7:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dual_dds_sine_mixer_unit.sv -----
// one tick at a time: in_stall is high from the accepting edge until the sequencer is back in idle;
// the seven-stage interpolation pipeline takes the main phase and, in the cycle after, the resonator
// phase; then come the mix and the write state, which waits while out_valid is held by out_stall
// reset: rst (synchronous) clears both phase accumulators, the sequencer and out_valid
// top level of the dual dds sine mixer; depends on ddsm_pkg, ddsm_ctrl, ddsm_datapath
`default_nettype none

module dual_dds_sine_mixer_unit #(
  parameter int TABLE_DEPTH         = ddsm_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_FRACTION_BITS = ddsm_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] main_step,
  input  wire logic [31:0] res_step,
  input  wire logic [7:0]  level8,
  input  wire logic [15:0] level_mul16,
  input  wire logic [15:0] res_amp16,
  input  wire logic        decay_active,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       dac_sample
);

  ddsm_pkg::cmd_t cmd;

  ddsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ddsm_datapath #(
    .TABLE_DEPTH         (TABLE_DEPTH),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .main_step    (main_step),
    .res_step     (res_step),
    .level8       (level8),
    .level_mul16  (level_mul16),
    .res_amp16    (res_amp16),
    .decay_active (decay_active),
    .dac_sample   (dac_sample)
  );

endmodule

`default_nettype wire

// ----- bench/dual_dds_sine_mixer_unit_test.sv -----
// self-checking bench for dual_dds_sine_mixer_unit: directed and random sample ticks
// with random gaps and output stalls, checked against an in-bench phase/sine predictor
// depends on ddsm_pkg and the dual_dds_sine_mixer_unit rtl
module dual_dds_sine_mixer_unit_test;

  localparam int TABLE_N = ddsm_pkg::TABLE_DEPTH_DEF;
  localparam int FRAC_W  = ddsm_pkg::PHASE_FRACTION_BITS_DEF;

  typedef struct packed {
    logic [31:0] main_step;
    logic [31:0] res_step;
    logic [7:0]  level8;
    logic [15:0] level_mul16;
    logic [15:0] res_amp16;
    logic        decay_active;
  } tick_t;

  class dac_scoreboard;
    logic [7:0]  sine_lut [TABLE_N];
    logic [31:0] main_ph;
    logic [31:0] res_ph;
    logic [7:0]  dac_due [$];
    int errors;
    int checked;
    int decay_ticks;
    int clamped;

    function new();
      real v;
      int t;
      main_ph = '0;
      res_ph = '0;
      errors = 0;
      checked = 0;
      decay_ticks = 0;
      clamped = 0;
      for (int i = 0; i < TABLE_N; i++) begin
        v = 128.0 + 127.0 * $sin(ddsm_pkg::TWO_PI * i / TABLE_N);
        sine_lut[i] = 8'($rtoi($floor(v + 0.5)));
        // exact halves round up
        if ((12 * i) % TABLE_N == 0) begin
          t = (12 * i) / TABLE_N;
          if (t == 1 || t == 5) sine_lut[i] = 8'd192;
          if (t == 7 || t == 11) sine_lut[i] = 8'd65;
        end
      end
    endfunction

    // interpolated sine minus the 128 bias
    function longint centered(logic [31:0] ph);
      int idx;
      int nxt;
      longint d;
      longint fr;
      idx = int'((ph >> FRAC_W) % TABLE_N);
      nxt = (idx + 1) % TABLE_N;
      fr = longint'(ph[FRAC_W-1:0]);
      d = longint'(sine_lut[nxt]) - longint'(sine_lut[idx]);
      return longint'(sine_lut[idx]) + ((d * fr) >>> FRAC_W) - 128;
    endfunction

    function void note_tick(tick_t t);
      longint cp;
      longint cr;
      longint g;
      longint rg;
      longint mixed;
      main_ph += t.main_step;
      cp = centered(main_ph);
      if (!t.decay_active) begin
        mixed = (cp * longint'(t.level8)) >>> 8;
      end else begin
        res_ph += t.res_step;
        cr = centered(res_ph);
        rg = (longint'(t.res_amp16) * 255) >>> 16;
        g = (longint'(t.level8) * longint'(t.level_mul16)) >>> 16;
        mixed = ((cp * g) >>> 8) + ((cr * rg) >>> 8);
        decay_ticks++;
      end
      mixed += 128;
      if (mixed < 0) begin
        mixed = 0;
        clamped++;
      end else if (mixed > 255) begin
        mixed = 255;
        clamped++;
      end
      dac_due.push_back(mixed[7:0]);
    endfunction

    function void check(logic [7:0] got);
      logic [7:0] want;
      if (dac_due.size() == 0) begin
        errors++;
        $display("%0t: dac_sample expected none, actual %0d", $time, got);
        return;
      end
      want = dac_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: dac_sample expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] main_step;
  logic [31:0] res_step;
  logic [7:0]  level8;
  logic [15:0] level_mul16;
  logic [15:0] res_amp16;
  logic        decay_active;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  dac_sample;

  dac_scoreboard sb = new();
  bit quiet;
  int hold;

  dual_dds_sine_mixer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .main_step(main_step),
    .res_step(res_step),
    .level8(level8),
    .level_mul16(level_mul16),
    .res_amp16(res_amp16),
    .decay_active(decay_active),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dac_sample(dac_sample)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic tick_t make_tick(logic [31:0] ms, logic [31:0] rs, logic [7:0] lvl,
                                      logic [15:0] mul, logic [15:0] amp, logic dec);
    tick_t t;
    t.main_step = ms;
    t.res_step = rs;
    t.level8 = lvl;
    t.level_mul16 = mul;
    t.res_amp16 = amp;
    t.decay_active = dec;
    return t;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_tick(tick_t t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    main_step = t.main_step;
    res_step = t.res_step;
    level8 = t.level8;
    level_mul16 = t.level_mul16;
    res_amp16 = t.res_amp16;
    decay_active = t.decay_active;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  // steps chosen so that the accumulators land on the given phases
  task automatic aim_tick(logic [31:0] main_at, logic [31:0] res_at, logic [7:0] lvl,
                          logic [15:0] mul, logic [15:0] amp, logic dec);
    send_tick(make_tick(main_at - sb.main_ph, dec ? res_at - sb.res_ph : 32'h0,
                        lvl, mul, amp, dec));
  endtask

  initial begin
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check(dac_sample);
        hold = quiet ? 0 : $urandom_range(0, 19);
      end else if (out_stall && hold > 0) begin
        hold--;
      end
      @(negedge clk);
      out_stall = (hold > 0);
    end
  end

  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    tick_t t;
    bit in_decay;
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    main_step = '0;
    res_step = '0;
    level8 = '0;
    level_mul16 = '0;
    res_amp16 = '0;
    decay_active = 1'b0;
    quiet = 1'b0;
    in_decay = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed ticks
    send_tick(make_tick(32'h0, 32'h0, 8'd255, 16'hFFFF, 16'h0, 1'b0));
    send_tick(make_tick(32'hFFFF_FFFF, 32'h0, 8'd255, 16'h0, 16'h0, 1'b0));
    send_tick(make_tick(32'h1, 32'h0, 8'd255, 16'h0, 16'h0, 1'b0));
    aim_tick(32'h0010_0000, 32'h0, 8'd255, 16'h0, 16'h0, 1'b0);
    aim_tick(32'h0010_0000, 32'h0, 8'd0, 16'h0, 16'h0, 1'b0);
    aim_tick(32'h0030_0000, 32'h0, 8'd255, 16'h0, 16'h0, 1'b0);
    aim_tick(32'h003F_8000, 32'h0, 8'd255, 16'h0, 16'h0, 1'b0);
    aim_tick(32'h0010_0000, 32'h0010_0000, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    aim_tick(32'h0030_0000, 32'h0030_0000, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    aim_tick(32'h0010_4000, 32'h0030_4321, 8'd255, 16'h0, 16'h0, 1'b1);
    send_tick(make_tick(32'h0001_2345, 32'hFFFF_FFFF, 8'd128, 16'h8000, 16'h8000, 1'b1));
    send_tick(make_tick(32'h0, 32'h0, 8'd200, 16'hFFFF, 16'hFFFF, 1'b1));
    send_tick(make_tick(32'h0003_1234, 32'hDEAD_BEEF, 8'd170, 16'h1234, 16'hABCD, 1'b0));
    send_tick(make_tick(32'h0003_1234, 32'h0001_1111, 8'd1, 16'h1, 16'h1, 1'b1));
    aim_tick(32'h0020_8000, 32'h003F_8000, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    aim_tick(32'h003F_FFFF, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(make_tick(32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h55, 16'hAAAA, 16'h5555, 1'b1));
    send_tick(make_tick(32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'hAA, 16'h5555, 16'hAAAA, 1'b0));

    // random ticks: mostly slow audio-like steps, with decay in runs
    for (int i = 0; i < 932; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) in_decay = ~in_decay;
      t.main_step = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 32'h003F_FFFF))
                                                  : 32'($urandom);
      t.res_step = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 32'h003F_FFFF))
                                                 : 32'($urandom);
      r = $urandom_range(0, 7);
      t.level8 = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
      r = $urandom_range(0, 7);
      t.level_mul16 = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
      r = $urandom_range(0, 7);
      t.res_amp16 = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
      t.decay_active = in_decay;
      send_tick(t);
    end
    in_valid = 1'b0;
    quiet = 1'b0;

    while (sb.dac_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d samples checked, %0d of them mixing the resonator, %0d clamped to a rail",
             sb.checked, sb.decay_ticks, sb.clamped);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
